// ----- rtl/stps_pkg.sv -----
// Shared types and constants for the slot table priority scheduler.
// Holds the beat field widths, request and status codes and the slot entry type.
// No dependencies.
`default_nettype none

package stps_pkg;

  localparam int unsigned HandleW = 32;
  localparam int unsigned PrioW   = 16;
  localparam int unsigned IdentW  = 32;
  localparam int unsigned IndexW  = 4;

  // Input beat: handle, priority, id packed from bit 0 up (80 bits, 10 bytes).
  localparam int unsigned InDataW  = HandleW + PrioW + IdentW;
  // Output beat: handle, priority, id, slot index, padded to 11 bytes.
  localparam int unsigned OutDataW = 88;

  // Request kinds carried in the input tuser.
  localparam logic KindEnqueue = 1'b0;
  localparam logic KindPop     = 1'b1;

  // Result status carried in the output tuser.
  localparam logic StatusOk   = 1'b0;
  localparam logic StatusFail = 1'b1;

  typedef struct packed {
    logic [IdentW-1:0]       ident;
    logic signed [PrioW-1:0] prio;
    logic [HandleW-1:0]      handle;
  } slot_entry_t;

endpackage : stps_pkg

`default_nettype wire

// ----- rtl/slot_table_priority_scheduler_top.sv -----
// Slot table priority scheduler: enqueue into the first free slot from a rotating
// cursor, pop the highest-priority job with rotating tie-break.
// Depends on stps_pkg.
`default_nettype none

// An enqueue probes one full flag per cycle from the insert cursor until it finds a free
// slot; a pop sweeps every slot once through the single memory read port. A failed
// request goes straight to the finish state. Requests are taken one at a time, only while
// the sequencer is idle; a new request is taken while the previous result still waits in
// the output register. Reset clears the full flags, the cursors and the job count at
// once; slot payloads are left as they are.
module slot_table_priority_scheduler_top import stps_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Request channel.
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // tdata: job_handle [31:0], priority_req [47:32], job_id [79:48]
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // tuser: kind [0]
  input  wire logic                s_axis_tuser_i,
  // Result channel.
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // tdata: out_handle [31:0], out_priority [47:32], out_id [79:48],
  //        slot_index [83:80], zero [87:84]
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  // tuser: status [0]
  output logic                     m_axis_tuser_o
);

  localparam int unsigned IdxW = $clog2(SLOTS);
  localparam int unsigned CntW = $clog2(SLOTS + 1);

  localparam logic [IdxW-1:0] LastIdx   = IdxW'(SLOTS - 1);
  localparam logic [CntW-1:0] SlotCount = CntW'(SLOTS);

  // Sequencer states.
  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StEnqScn = 2'd1;
  localparam logic [1:0] StPopScn = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  // Control state.
  logic [1:0]       state_q, state_d;
  logic [SLOTS-1:0] full_q, full_d;
  logic [IdxW-1:0]  ins_cur_q, ins_cur_d;
  logic [IdxW-1:0]  pop_cur_q, pop_cur_d;
  logic [CntW-1:0]  jobs_q, jobs_d;
  logic [IdxW-1:0]  scan_idx_q, scan_idx_d;
  logic [CntW-1:0]  scan_cnt_q, scan_cnt_d;
  logic             rd_vld_q, rd_vld_d;
  logic             found_q, found_d;
  logic             out_valid_q, out_valid_d;

  // Payload registers, no reset needed.
  slot_entry_t      req_q;
  slot_entry_t      rd_data_q;
  logic [IdxW-1:0]  rd_idx_q;
  slot_entry_t      best_q, best_d;
  logic [IdxW-1:0]  best_idx_q, best_idx_d;
  logic             res_status_q, res_status_d;
  slot_entry_t      res_entry_q, res_entry_d;
  logic [IdxW-1:0]  res_idx_q, res_idx_d;
  logic             out_status_q;
  slot_entry_t      out_entry_q;
  logic [IndexW-1:0] out_idx_q;

  // Slot payload memory: one write port, one registered read port.
  slot_entry_t      mem [SLOTS];
  logic             mem_we, mem_re;
  logic [IdxW-1:0]  mem_wr_addr;

  logic             in_fire;
  logic             out_free;
  logic [IdxW-1:0]  scan_next;
  logic [IdxW+IndexW-1:0] res_idx_ext;
  slot_entry_t      in_entry;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == StIdle);

  assign in_entry = slot_entry_t'(s_axis_tdata_i);
  assign scan_next = (scan_idx_q == LastIdx) ? '0 : scan_idx_q + 1'b1;
  // Only the low bits of the slot index are reported.
  assign res_idx_ext = {{IndexW{1'b0}}, res_idx_q};

  always_comb begin
    state_d      = state_q;
    full_d       = full_q;
    ins_cur_d    = ins_cur_q;
    pop_cur_d    = pop_cur_q;
    jobs_d       = jobs_q;
    scan_idx_d   = scan_idx_q;
    scan_cnt_d   = scan_cnt_q;
    rd_vld_d     = 1'b0;
    found_d      = found_q;
    best_d       = best_q;
    best_idx_d   = best_idx_q;
    res_status_d = res_status_q;
    res_entry_d  = res_entry_q;
    res_idx_d    = res_idx_q;
    out_valid_d  = out_valid_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_wr_addr  = scan_idx_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          res_status_d = StatusFail;
          res_entry_d  = '0;
          res_idx_d    = '0;
          scan_cnt_d   = '0;
          found_d      = 1'b0;
          if (s_axis_tuser_i == KindEnqueue) begin
            if (jobs_q == SlotCount) begin
              // Table full: fail and leave the insert cursor alone.
              state_d = StFinish;
            end else begin
              scan_idx_d = ins_cur_q;
              ins_cur_d  = (ins_cur_q == LastIdx) ? '0 : ins_cur_q + 1'b1;
              state_d    = StEnqScn;
            end
          end else begin
            // A pop advances its cursor even on an empty table.
            pop_cur_d  = (pop_cur_q == LastIdx) ? '0 : pop_cur_q + 1'b1;
            scan_idx_d = pop_cur_q;
            state_d    = (jobs_q == '0) ? StFinish : StPopScn;
          end
        end
      end

      StEnqScn: begin
        // A free slot is known to exist, so this probe loop terminates.
        if (!full_q[scan_idx_q]) begin
          full_d[scan_idx_q] = 1'b1;
          mem_we       = 1'b1;
          mem_wr_addr  = scan_idx_q;
          jobs_d       = jobs_q + 1'b1;
          res_status_d = StatusOk;
          res_idx_d    = scan_idx_q;
          state_d      = StFinish;
        end else begin
          scan_idx_d = scan_next;
        end
      end

      StPopScn: begin
        // Issue one read per cycle in rotated order.
        if (scan_cnt_q != SlotCount) begin
          mem_re     = 1'b1;
          rd_vld_d   = 1'b1;
          scan_cnt_d = scan_cnt_q + 1'b1;
          scan_idx_d = scan_next;
        end
        // Compare the entry read in the previous cycle; strict greater keeps
        // the earliest slot on a tie.
        if (rd_vld_q && full_q[rd_idx_q]) begin
          if (!found_q || (rd_data_q.prio > best_q.prio)) begin
            found_d    = 1'b1;
            best_d     = rd_data_q;
            best_idx_d = rd_idx_q;
          end
        end
        if ((scan_cnt_q == SlotCount) && !rd_vld_q) begin
          full_d[best_idx_q] = 1'b0;
          jobs_d       = jobs_q - 1'b1;
          res_status_d = StatusOk;
          res_entry_d  = best_q;
          res_idx_d    = best_idx_q;
          state_d      = StFinish;
        end
      end

      StFinish: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      full_q      <= '0;
      ins_cur_q   <= '0;
      pop_cur_q   <= '0;
      jobs_q      <= '0;
      scan_idx_q  <= '0;
      scan_cnt_q  <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      full_q      <= full_d;
      ins_cur_q   <= ins_cur_d;
      pop_cur_q   <= pop_cur_d;
      jobs_q      <= jobs_d;
      scan_idx_q  <= scan_idx_d;
      scan_cnt_q  <= scan_cnt_d;
      rd_vld_q    <= rd_vld_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_entry;
    end
    best_q       <= best_d;
    best_idx_q   <= best_idx_d;
    res_status_q <= res_status_d;
    res_entry_q  <= res_entry_d;
    res_idx_q    <= res_idx_d;
    if ((state_q == StFinish) && out_free) begin
      out_status_q <= res_status_q;
      out_entry_q  <= res_entry_q;
      out_idx_q    <= res_idx_ext[IndexW-1:0];
    end
  end

  // Slot payload memory.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wr_addr] <= req_q;
    end
    if (mem_re) begin
      rd_data_q <= mem[scan_idx_q];
      rd_idx_q  <= scan_idx_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {{(OutDataW - InDataW - IndexW){1'b0}}, out_idx_q,
                            out_entry_q.ident, out_entry_q.prio, out_entry_q.handle};

endmodule : slot_table_priority_scheduler_top

`default_nettype wire

// ----- verif/slot_table_priority_scheduler_top_tb.sv -----
// Self-checking testbench for slot_table_priority_scheduler_top: directed and random
// enqueue/pop beats, checked against a behavioral slot table predictor.
// Depends on stps_pkg and the scheduler RTL.
module slot_table_priority_scheduler_top_tb;
  import stps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumSlots    = 16;
  localparam int RandomBeats = 1100;
  localparam int QuietBeats  = 150;
  localparam int CycleLimit  = 600000;

  // One expected result beat, split into its fields.
  typedef struct {
    logic                    status;
    logic [HandleW-1:0]      handle;
    logic signed [PrioW-1:0] prio;
    logic [IdentW-1:0]       ident;
    logic [IndexW-1:0]       index;
  } sched_result_t;

  // One row of the directed stimulus. Rows with has_want set carry a result that is
  // obvious by inspection; the others are predicted.
  typedef struct {
    logic                    kind;
    logic [HandleW-1:0]      handle;
    logic signed [PrioW-1:0] prio;
    logic [IdentW-1:0]       ident;
    bit                      has_want;
    sched_result_t           want;
  } request_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic                s_axis_tuser_i = KindEnqueue;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;

  slot_table_priority_scheduler_top #(
    .SLOTS(NumSlots)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the slot table, updated once per accepted request beat.
  logic                    tbl_full   [NumSlots];
  logic [HandleW-1:0]      tbl_handle [NumSlots];
  logic signed [PrioW-1:0] tbl_prio   [NumSlots];
  logic [IdentW-1:0]       tbl_ident  [NumSlots];
  int                      ins_ptr;
  int                      pop_ptr;
  int                      occupancy;

  sched_result_t pending_results[$];
  int            errors = 0;
  int            cycles = 0;
  bit            quiet_tail = 1'b0;
  int            ready_stall = 0;

  // Works out the result of one request and applies it to the shadow table.
  function automatic sched_result_t schedule_request(logic kind, logic [HandleW-1:0] handle,
                                                     logic signed [PrioW-1:0] prio,
                                                     logic [IdentW-1:0] ident);
    sched_result_t           res;
    int                      start;
    int                      slot;
    int                      best;
    logic signed [PrioW-1:0] best_prio;
    res = '{status: StatusFail, handle: '0, prio: '0, ident: '0, index: '0};
    best = -1;
    best_prio = '0;
    if (kind == KindEnqueue) begin
      // A full table rejects the job and leaves the insert cursor alone.
      if (occupancy < NumSlots) begin
        start = ins_ptr;
        ins_ptr = (start + 1) % NumSlots;
        for (int off = 0; off < NumSlots; off++) begin
          slot = (start + off) % NumSlots;
          if (!tbl_full[slot] && best < 0) begin
            best = slot;
          end
        end
        tbl_full[best]   = 1'b1;
        tbl_handle[best] = handle;
        tbl_prio[best]   = prio;
        tbl_ident[best]  = ident;
        occupancy++;
        res.status = StatusOk;
        res.index  = best[IndexW-1:0];
      end
    end else begin
      // The pop cursor moves even when the table is empty. Strictly greater wins,
      // so on a tie the first slot met from the old cursor is kept.
      start = pop_ptr;
      pop_ptr = (start + 1) % NumSlots;
      for (int off = 0; off < NumSlots; off++) begin
        slot = (start + off) % NumSlots;
        if (tbl_full[slot] && (best < 0 || tbl_prio[slot] > best_prio)) begin
          best = slot;
          best_prio = tbl_prio[slot];
        end
      end
      if (best >= 0) begin
        tbl_full[best] = 1'b0;
        occupancy--;
        res.status = StatusOk;
        res.handle = tbl_handle[best];
        res.prio   = tbl_prio[best];
        res.ident  = tbl_ident[best];
        res.index  = best[IndexW-1:0];
      end
    end
    return res;
  endfunction

  function automatic request_row_t make_row(logic kind, logic [HandleW-1:0] handle,
                                            logic signed [PrioW-1:0] prio,
                                            logic [IdentW-1:0] ident);
    request_row_t row;
    row.kind = kind;
    row.handle = handle;
    row.prio = prio;
    row.ident = ident;
    row.has_want = 1'b0;
    row.want = '{status: StatusFail, handle: '0, prio: '0, ident: '0, index: '0};
    return row;
  endfunction

  // Drives one request beat, with an optional idle burst in front of it, and waits
  // for the handshake. tvalid stays high afterward so back-to-back beats never
  // lower and raise it within one time step.
  task automatic send_request(request_row_t row);
    sched_result_t res;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {row.ident, row.prio, row.handle};
    s_axis_tuser_i  <= row.kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    res = schedule_request(row.kind, row.handle, row.prio, row.ident);
    pending_results.push_back(row.has_want ? row.want : res);
  endtask

  // Holds the request side idle until every outstanding result has come back.
  task automatic hold_until_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic compare_field(string field, logic [IdentW-1:0] want, logic [IdentW-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      errors++;
    end
  endtask

  // Result side: random stall bursts, none in the tail of the run.
  always @(posedge clk_i) begin
    if (quiet_tail || !rst_ni) begin
      ready_stall = 0;
      m_axis_tready_i <= rst_ni;
    end else if (ready_stall > 0) begin
      ready_stall--;
      m_axis_tready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      ready_stall = $urandom_range(1, 17) - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Every accepted result beat is matched against the oldest expectation.
  always @(posedge clk_i) begin
    sched_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no request outstanding: tdata 0x%0h", m_axis_tdata_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status", 32'(want.status), 32'(m_axis_tuser_o));
        compare_field("out_handle", want.handle, m_axis_tdata_o[31:0]);
        compare_field("out_priority", 32'(want.prio[15:0]), 32'(m_axis_tdata_o[47:32]));
        compare_field("out_id", want.ident, m_axis_tdata_o[79:48]);
        compare_field("slot_index", 32'(want.index), 32'(m_axis_tdata_o[83:80]));
        compare_field("tdata padding", 32'd0, 32'(m_axis_tdata_o[87:84]));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    request_row_t directed[$];
    request_row_t row;
    int           fill_bias;

    for (int s = 0; s < NumSlots; s++) begin
      tbl_full[s] = 1'b0;
      tbl_handle[s] = '0;
      tbl_prio[s] = '0;
      tbl_ident[s] = '0;
    end
    ins_ptr = 0;
    pop_ptr = 0;
    occupancy = 0;

    // Directed part. A pop right after reset finds the table empty.
    row = make_row(KindPop, '1, 16'sh7fff, '1);
    row.has_want = 1'b1;
    directed.push_back(row);
    // First enqueue lands in slot 0, carrying all-ones fields and the top priority.
    row = make_row(KindEnqueue, '1, 16'sh7fff, '1);
    row.has_want = 1'b1;
    row.want = '{status: StatusOk, handle: '0, prio: '0, ident: '0, index: 4'd0};
    directed.push_back(row);
    // Second enqueue lands in slot 1 with all-zero fields and the lowest priority.
    row = make_row(KindEnqueue, '0, -16'sh8000, '0);
    row.has_want = 1'b1;
    row.want = '{status: StatusOk, handle: '0, prio: '0, ident: '0, index: 4'd1};
    directed.push_back(row);
    // Fill the rest of the table with equal priorities so pops exercise the tie-break.
    for (int s = 2; s < NumSlots; s++) begin
      directed.push_back(make_row(KindEnqueue, 32'h1000_0000 + s, 16'sd5, 32'hA000_0000 + s));
    end
    // Enqueue into a full table is rejected.
    row = make_row(KindEnqueue, 32'h5555_AAAA, 16'sd1, 32'hAAAA_5555);
    row.has_want = 1'b1;
    directed.push_back(row);
    // The top-priority job in slot 0 wins whatever the cursor says.
    row = make_row(KindPop, '0, '0, '0);
    row.has_want = 1'b1;
    row.want = '{status: StatusOk, handle: '1, prio: 16'sh7fff, ident: '1, index: 4'd0};
    directed.push_back(row);
    // Refill slot 0 with a tying priority, then pop through the ties.
    directed.push_back(make_row(KindEnqueue, 32'hDEAD_0000, 16'sd5, 32'h0000_BEEF));
    repeat (5) directed.push_back(make_row(KindPop, '1, -16'sd1, '1));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[n]) send_request(directed[n]);
    hold_until_drained();

    // Random part: the enqueue/pop mix shifts every 64 beats so the table keeps
    // swinging between empty and full.
    fill_bias = 60;
    for (int n = 0; n < RandomBeats; n++) begin
      if (n % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: fill_bias = 90;
          1: fill_bias = 10;
          default: fill_bias = $urandom_range(30, 70);
        endcase
      end
      if (n == RandomBeats - QuietBeats) quiet_tail = 1'b1;
      if (n == 400 || n == 800) hold_until_drained();
      row = make_row(($urandom_range(0, 99) < fill_bias) ? KindEnqueue : KindPop,
                     $urandom(), 16'($urandom()), $urandom());
      case ($urandom_range(0, 3))
        0: row.prio = 16'(int'($urandom_range(0, 4)) - 2);
        1: row.prio = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
        default: ;
      endcase
      send_request(row);
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * NumSlots + 8) @(posedge clk_i);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- slot_table_priority_scheduler_top.f -----
rtl/stps_pkg.sv
rtl/slot_table_priority_scheduler_top.sv
verif/slot_table_priority_scheduler_top_tb.sv
